### rtl/gmm_pkg.sv
`timescale 1ns / 1ps

package gmm_pkg;

    localparam int GasW     = 63;
    localparam int AddrW    = 64;
    localparam int CapW     = 31;
    localparam int BytesW   = 32;
    localparam int CostW    = 44;
    localparam int WordsW   = 27;

    localparam logic [CapW-1:0] CapReset = CapW'(4 * 1024 * 1024);

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_CHARGE = 2'd1,
        CMD_EXPAND = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_OOG = 2'd1,
        ST_OOM = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [GasW-1:0]  amount;
        logic [AddrW-1:0] offset;
        logic [AddrW-1:0] size;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [GasW-1:0]   gas_left;
        logic [BytesW-1:0] memory_bytes;
    } result_t;

endpackage

### rtl/evm_gas_memory_meter.sv
`timescale 1ns / 1ps

// Gas and memory-size meter. Each transaction on the input channel is one
// command (start, charge or expand) and yields exactly one result transaction
// with the status, the gas left and the memory size in bytes. The block takes
// one transaction per cycle while the output channel does not stall: an item
// sits in the input register, where its cost and the new meter state are
// worked out, and then lands in the result register, so the state update of
// one item is seen by the next one without a gap. The result register holds a
// result while the output channel stalls, and the input register still takes
// one more item in that time. The memory capacity register may only be written
// while no transaction is in flight.
module evm_gas_memory_meter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [gmm_pkg::CapW-1:0]    cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  cmd,
    input  logic [gmm_pkg::GasW-1:0]    amount,
    input  logic [gmm_pkg::AddrW-1:0]   offset,
    input  logic [gmm_pkg::AddrW-1:0]   size,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [gmm_pkg::GasW-1:0]    gas_left,
    output logic [gmm_pkg::BytesW-1:0]  memory_bytes
);

    logic [gmm_pkg::CapW-1:0] capacity_reg;
    logic                     in_valid_reg,  in_valid_next;
    gmm_pkg::item_t           item_reg;
    logic                     out_valid_reg, out_valid_next;
    gmm_pkg::result_t         result_reg;
    gmm_pkg::result_t         result;
    logic                     advance;
    logic                     fire;
    logic                     in_accept;

    assign advance   = !out_valid_reg || out_ready;
    assign fire      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= gmm_pkg::CapReset;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.cmd    <= gmm_pkg::cmd_t'(cmd);
            item_reg.amount <= amount;
            item_reg.offset <= offset;
            item_reg.size   <= size;
        end
        if (fire)
        begin
            result_reg <= result;
        end
    end

    gmm_meter u_meter (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (item_reg),
        .capacity (capacity_reg),
        .result   (result)
    );

    assign out_valid    = out_valid_reg;
    assign status       = result_reg.status;
    assign gas_left     = result_reg.gas_left;
    assign memory_bytes = result_reg.memory_bytes;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("Input stalled while the result register was empty.");

    a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("A processed transaction produced no result.");

endmodule

### rtl/gmm_cost.sv
`timescale 1ns / 1ps

module gmm_cost (
    input  logic [gmm_pkg::CapW-1:0]   end_addr,
    output logic [gmm_pkg::BytesW-1:0] rounded_bytes,
    output logic [gmm_pkg::CostW-1:0]  cost
);

    logic [gmm_pkg::BytesW-1:0]   round_sum;
    logic [gmm_pkg::WordsW-1:0]   words;
    logic [2*gmm_pkg::WordsW-1:0] words_sq;
    logic [gmm_pkg::CostW:0]      cost_full;

    // Round the end address up to whole 32-byte words.
    assign round_sum     = gmm_pkg::BytesW'(end_addr) + gmm_pkg::BytesW'(31);
    assign words         = round_sum[gmm_pkg::BytesW-1:5];
    assign rounded_bytes = {words, 5'd0};

    // Expansion cost is 3w plus the square of w divided by 512.
    assign words_sq  = words * words;
    assign cost_full = (gmm_pkg::CostW+1)'(words) + (gmm_pkg::CostW+1)'({words, 1'b0})
                     + (gmm_pkg::CostW+1)'(words_sq[2*gmm_pkg::WordsW-1:9]);
    assign cost      = cost_full[gmm_pkg::CostW-1:0];

endmodule

### rtl/gmm_meter.sv
`timescale 1ns / 1ps

module gmm_meter (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  gmm_pkg::item_t            item,
    input  logic [gmm_pkg::CapW-1:0]  capacity,
    output gmm_pkg::result_t          result
);

    logic [gmm_pkg::GasW-1:0]   gas_reg,     gas_next;
    logic [gmm_pkg::BytesW-1:0] active_reg,  active_next;
    logic [gmm_pkg::CostW-1:0]  charged_reg, charged_next;
    gmm_pkg::status_t           status;

    logic [gmm_pkg::AddrW:0]    end_sum;
    logic                       end_wrap;
    logic                       covered;
    logic                       over_cap;
    logic [gmm_pkg::BytesW-1:0] rounded_bytes;
    logic [gmm_pkg::CostW-1:0]  cost;
    logic [gmm_pkg::CostW-1:0]  cost_diff;
    logic                       need_gas;
    logic                       exp_short;
    logic                       chg_short;

    assign end_sum  = {1'b0, item.offset} + {1'b0, item.size};
    assign end_wrap = end_sum[gmm_pkg::AddrW];
    assign covered  = end_sum[gmm_pkg::AddrW-1:0] <= gmm_pkg::AddrW'(active_reg);
    assign over_cap = end_sum[gmm_pkg::AddrW-1:0] > gmm_pkg::AddrW'(capacity);

    gmm_cost u_cost (
        .end_addr      (end_sum[gmm_pkg::CapW-1:0]),
        .rounded_bytes (rounded_bytes),
        .cost          (cost)
    );

    assign need_gas  = cost > charged_reg;
    assign cost_diff = cost - charged_reg;
    assign exp_short = gas_reg < gmm_pkg::GasW'(cost_diff);
    assign chg_short = gas_reg < item.amount;

    always_comb
    begin
        gas_next     = gas_reg;
        active_next  = active_reg;
        charged_next = charged_reg;
        status       = gmm_pkg::ST_OK;
        unique case (item.cmd)
            gmm_pkg::CMD_START:
            begin
                gas_next     = item.amount;
                active_next  = '0;
                charged_next = '0;
            end
            gmm_pkg::CMD_CHARGE:
            begin
                if (chg_short)
                begin
                    gas_next = '0;
                    status   = gmm_pkg::ST_OOG;
                end
                else
                begin
                    gas_next = gas_reg - item.amount;
                end
            end
            gmm_pkg::CMD_EXPAND:
            begin
                if (item.size == '0 || (!end_wrap && covered))
                begin
                    status = gmm_pkg::ST_OK;
                end
                else if (end_wrap)
                begin
                    status = gmm_pkg::ST_OOG;
                end
                else if (over_cap)
                begin
                    status = gmm_pkg::ST_OOM;
                end
                else if (need_gas && exp_short)
                begin
                    gas_next = '0;
                    status   = gmm_pkg::ST_OOG;
                end
                else
                begin
                    if (need_gas)
                    begin
                        gas_next     = gas_reg - gmm_pkg::GasW'(cost_diff);
                        charged_next = cost;
                    end
                    active_next = rounded_bytes;
                end
            end
            default:
            begin
                status = gmm_pkg::ST_OK;
            end
        endcase
    end

    assign result.status       = status;
    assign result.gas_left     = gas_next;
    assign result.memory_bytes = active_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gas_reg     <= '0;
            active_reg  <= '0;
            charged_reg <= '0;
        end
        else if (fire)
        begin
            gas_reg     <= gas_next;
            active_reg  <= active_next;
            charged_reg <= charged_next;
        end
    end

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(gas_reg) && $stable(active_reg) && $stable(charged_reg))
        else $error("Meter state changed without a transaction.");

    a_oom_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        fire && status == gmm_pkg::ST_OOM |=> $stable(gas_reg) && $stable(active_reg))
        else $error("Out of memory changed gas or memory size.");

    a_charge_oog_empties: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.cmd == gmm_pkg::CMD_CHARGE && status == gmm_pkg::ST_OOG
        |=> gas_reg == '0)
        else $error("Failed charge did not empty the gas.");

    a_active_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg[4:0] == 5'd0)
        else $error("Memory size is not a whole number of words.");

endmodule
